>>> rtl/indexed_insert_erase_array_macros.svh
// ----------------------------------------------------------------------------
// Indexed insert/erase array assertion macros
// Shared assertion forms for the array checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_ERASE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_ERASE_ARRAY_MACROS_SVH

// check while out of reset
`define IAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define IAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ias_pkg.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array package
// Transaction types, command and status codes, and cell control.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int SLOT_BITS  = 5;
  localparam int COUNT_BITS = 5;
  localparam int VALUE_BITS = 32;

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_ERASE    = 2'd2,
    CMD_TRUNCATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_READ_OOB = 2'd1,
    ST_BAD_POS  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] read_value;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic                 shift_up;
    logic                 shift_down;
    logic [SLOT_BITS-1:0] pos;
  } cell_ctl_t;

endpackage

>>> rtl/indexed_insert_erase_array.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array
// Ordered element array with read, insert, erase and truncate commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one command transaction: read, insert,
//   erase or truncate, with a slot and write data. Every command returns one
//   transaction on out_valid/out_stall/out_data with status, read value and
//   the element count after the command.
//   The result sits in the output register on the edge after the command is
//   taken. Throughput is one command per cycle while no result is held under
//   out_stall, set by the row of cells, each of which loads from a neighbor.
//   While a result waits under out_stall, in_stall is raised and the result
//   and array hold. A new command is taken in the same cycle the held result
//   leaves.
//   Reset clears the count and the output valid; element contents are not
//   cleared, and only elements below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_insert_erase_array #(
  parameter int DEPTH        = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ias_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ias_pkg::out_item_t out_data
);

  localparam int FillBits = $clog2(DEPTH + 1);
  localparam int CmpBits  = (FillBits > ias_pkg::SLOT_BITS) ? FillBits : ias_pkg::SLOT_BITS;
  localparam int WideBits = (ELEMENT_BITS > ias_pkg::VALUE_BITS) ?
                            ELEMENT_BITS : ias_pkg::VALUE_BITS;

  logic [FillBits-1:0]     fill_r;
  logic [FillBits-1:0]     fill_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  ias_pkg::out_item_t      out_data_r;
  ias_pkg::out_item_t      out_data_nxt;

  logic                    accept;
  logic [CmpBits-1:0]      fill_x;
  logic [CmpBits-1:0]      slot_x;
  logic [CmpBits-1:0]      fill_nxt_x;
  logic [WideBits-1:0]     wr_wide;
  logic [WideBits-1:0]     rd_wide;
  logic [ELEMENT_BITS-1:0] wr_elem;
  logic [ELEMENT_BITS-1:0] rd_elem;
  ias_pkg::status_t        status;
  ias_pkg::cell_ctl_t      ctl;

  logic [ELEMENT_BITS-1:0] cell_val [DEPTH];

  assign accept  = in_valid && !in_stall;
  assign fill_x  = CmpBits'(fill_r);
  assign slot_x  = CmpBits'(in_data.slot);
  assign wr_wide = WideBits'(in_data.write_value);
  assign wr_elem = wr_wide[ELEMENT_BITS-1:0];

  always_comb begin
    rd_elem = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CmpBits'(i) == slot_x) begin
        rd_elem = rd_elem | cell_val[i];
      end
    end
  end

  always_comb begin
    status         = ias_pkg::ST_OK;
    fill_nxt       = fill_r;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.pos        = in_data.slot;
    rd_wide        = '0;
    case (in_data.cmd)
      ias_pkg::CMD_READ: begin
        if (slot_x >= fill_x) begin
          status = ias_pkg::ST_READ_OOB;
        end else begin
          rd_wide = WideBits'(rd_elem);
        end
      end
      ias_pkg::CMD_INSERT: begin
        if (slot_x > fill_x) begin
          status = ias_pkg::ST_BAD_POS;
        end else if (fill_r == FillBits'(DEPTH)) begin
          status = ias_pkg::ST_FULL;
        end else begin
          ctl.shift_up = accept;
          fill_nxt     = fill_r + FillBits'(1);
        end
      end
      ias_pkg::CMD_ERASE: begin
        if (slot_x >= fill_x) begin
          status = ias_pkg::ST_BAD_POS;
        end else begin
          ctl.shift_down = accept;
          fill_nxt       = fill_r - FillBits'(1);
        end
      end
      ias_pkg::CMD_TRUNCATE: begin
        if (slot_x < fill_x) begin
          fill_nxt = slot_x[FillBits-1:0];
        end
      end
      default: begin
        status = ias_pkg::ST_OK;
      end
    endcase
  end

  assign fill_nxt_x = CmpBits'(fill_nxt);

  always_comb begin
    out_data_nxt.status     = status;
    out_data_nxt.read_value = rd_wide[ias_pkg::VALUE_BITS-1:0];
    out_data_nxt.count      = fill_nxt_x[ias_pkg::COUNT_BITS-1:0];
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_in;
    logic [ELEMENT_BITS-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_val[g+1];
    end

    ias_cell #(
      .IDX          (g),
      .ELEMENT_BITS (ELEMENT_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_data   (wr_elem),
      .left_in   (left_in),
      .right_in  (right_in),
      .value_out (cell_val[g])
    );
  end

  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/ias_cell.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array cell
// One element register; loads from its left or right neighbor or new data.
// ----------------------------------------------------------------------------
module ias_cell #(
  parameter int IDX          = 0,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                    clk,
  input  ias_pkg::cell_ctl_t      ctl,
  input  logic [ELEMENT_BITS-1:0] wr_data,
  input  logic [ELEMENT_BITS-1:0] left_in,
  input  logic [ELEMENT_BITS-1:0] right_in,
  output logic [ELEMENT_BITS-1:0] value_out
);

  logic [ELEMENT_BITS-1:0] val_r;
  logic [ELEMENT_BITS-1:0] val_nxt;
  int                      pos_i;

  always_comb begin
    pos_i   = int'(ctl.pos);
    val_nxt = val_r;
    if (ctl.shift_up) begin
      if (IDX > pos_i) begin
        val_nxt = left_in;
      end else if (IDX == pos_i) begin
        val_nxt = wr_data;
      end
    end else if (ctl.shift_down && (IDX >= pos_i)) begin
      val_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value_out = val_r;

endmodule

>>> rtl/ias_checker.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array checker
// Port-level properties of the array, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "indexed_insert_erase_array_macros.svh"

module ias_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ias_pkg::out_item_t out_data
);

  logic in_take;
  logic out_hold;
  logic out_fail;
  logic count_ok;

  assign in_take  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;
  assign out_fail = out_valid && (out_data.status != ias_pkg::ST_OK);
  assign count_ok = (DEPTH > 31) || (int'(out_data.count) <= DEPTH);

  `IAS_ASSERT(a_hold_result, out_hold |=> out_valid && $stable(out_data), "held result changed")
  `IAS_ASSERT(a_one_cycle, in_take |=> out_valid, "no result after accepted command")
  `IAS_ASSERT(a_zero_value, out_fail |-> out_data.read_value == '0, "nonzero value on failure")
  `IAS_ASSERT(a_count_max, out_valid |-> count_ok, "count above depth")
  `IAS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind indexed_insert_erase_array ias_checker #(.DEPTH(DEPTH)) u_ias_checker (.*);

>>> bench/indexed_insert_erase_array_tb.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array testbench
// Drives read, insert, erase and truncate transactions through the
// valid/stall channels and predicts each result from a local copy of the
// array and its count. A scoreboard checks every result field in order.
// Both sides idle in random bursts, and the receiver holds off once for a
// long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module indexed_insert_erase_array_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ias_pkg::*;

  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = VALUE_BITS;
  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_FROM   = 1600;
  localparam int PRESSURE_AT  = 800;
  localparam int HOLD_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  class array_scoreboard;
    logic [ELEMENT_BITS-1:0] cells [DEPTH];
    int unsigned fill;
    out_item_t expected_q[$];
    int unsigned errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_command(in_item_t it);
      out_item_t r;
      int unsigned pos;
      int unsigned i;
      r.status = ST_OK;
      r.read_value = '0;
      pos = 32'(it.slot);
      case (it.cmd)
        CMD_READ: begin
          if (pos >= fill) r.status = ST_READ_OOB;
          else r.read_value = cells[pos];
        end
        CMD_INSERT: begin
          if (pos > fill) begin
            r.status = ST_BAD_POS;
          end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = it.write_value[ELEMENT_BITS-1:0];
            fill++;
          end
        end
        CMD_ERASE: begin
          if (pos >= fill) begin
            r.status = ST_BAD_POS;
          end else begin
            for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        default: begin
          if (pos < fill) fill = pos;
        end
      endcase
      r.count = fill[COUNT_BITS-1:0];
      expected_q.push_back(r);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (status %0d count %0d)",
                         got.status, got.count));
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
        if (got.count !== want.count)
          report($sformatf("count %0d, expected %0d", got.count, want.count));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  array_scoreboard sb = new();

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  int pressure_left = 0;
  int unsigned cycles = 0;

  indexed_insert_erase_array #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic in_item_t make_item(cmd_t c, int unsigned s, logic [31:0] v);
    in_item_t it;
    it.cmd = c;
    it.slot = s[SLOT_BITS-1:0];
    it.write_value = v;
    return it;
  endfunction

  function automatic int unsigned valid_slot();
    if (sb.fill == 0) return 0;
    return $urandom_range(0, sb.fill - 1);
  endfunction

  function automatic in_item_t random_item(phase_t ph);
    in_item_t it;
    int unsigned roll;
    int unsigned pick;
    cmd_t c;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    it.write_value = $urandom();
    if (roll < 12) begin
      c = cmd_t'($urandom_range(0, 3));
      it.cmd = c;
      it.slot = SLOT_BITS'($urandom_range(0, 31));
      return it;
    end
    case (ph)
      PH_GROW: begin
        if (pick < 65) c = CMD_INSERT;
        else if (pick < 85) c = CMD_READ;
        else if (pick < 95) c = CMD_ERASE;
        else c = CMD_TRUNCATE;
      end
      PH_SHRINK: begin
        if (pick < 50) c = CMD_ERASE;
        else if (pick < 75) c = CMD_READ;
        else if (pick < 88) c = CMD_INSERT;
        else c = CMD_TRUNCATE;
      end
      default: begin
        if (pick < 35) c = CMD_INSERT;
        else if (pick < 65) c = CMD_READ;
        else if (pick < 92) c = CMD_ERASE;
        else c = CMD_TRUNCATE;
      end
    endcase
    it.cmd = c;
    case (c)
      CMD_INSERT:   it.slot = SLOT_BITS'($urandom_range(0, sb.fill));
      CMD_TRUNCATE: it.slot = SLOT_BITS'($urandom_range(0, sb.fill + 1));
      default:      it.slot = SLOT_BITS'((roll < 18) ? sb.fill : valid_slot());
    endcase
    return it;
  endfunction

  task automatic send_command(in_item_t it);
    int gap;
    if (tx_idle_on && pressure_left == 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_command(it);
    if (pressure_left > 0) pressure_left--;
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("indexed_insert_erase_array_tb: FAIL");
    $finish;
  end

  initial begin
    phase_t ph;
    int guard;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(make_item(CMD_READ,     0,  32'h0));
    send_command(make_item(CMD_ERASE,    0,  32'h0));
    send_command(make_item(CMD_INSERT,   1,  32'h1234_5678));
    send_command(make_item(CMD_TRUNCATE, 0,  32'h0));
    send_command(make_item(CMD_INSERT,   0,  32'h0000_0000));
    send_command(make_item(CMD_INSERT,   0,  32'hFFFF_FFFF));
    send_command(make_item(CMD_INSERT,   2,  32'hA5A5_A5A5));
    send_command(make_item(CMD_INSERT,   1,  32'h5A5A_5A5A));
    send_command(make_item(CMD_READ,     0,  32'h0));
    send_command(make_item(CMD_READ,     1,  32'h0));
    send_command(make_item(CMD_READ,     2,  32'h0));
    send_command(make_item(CMD_READ,     3,  32'h0));
    send_command(make_item(CMD_READ,     4,  32'h0));
    send_command(make_item(CMD_READ,     31, 32'hFFFF_FFFF));
    send_command(make_item(CMD_INSERT,   31, 32'hFFFF_FFFF));
    send_command(make_item(CMD_ERASE,    4,  32'h0));
    send_command(make_item(CMD_ERASE,    1,  32'h0));
    send_command(make_item(CMD_TRUNCATE, 31, 32'h0));
    send_command(make_item(CMD_TRUNCATE, 3,  32'h0));
    send_command(make_item(CMD_TRUNCATE, 1,  32'h0));
    send_command(make_item(CMD_READ,     0,  32'h0));
    send_command(make_item(CMD_ERASE,    0,  32'h0));
    send_command(make_item(CMD_READ,     0,  32'h0));

    ph = PH_GROW;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    ph = PH_GROW;
          2:       ph = PH_SHRINK;
          default: ph = PH_MIXED;
        endcase
      end
      if (n % 100 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (n == PRESSURE_AT) begin
        hold_req = 1'b1;
        pressure_left = 40;
      end
      if (n >= QUIET_FROM) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_command(random_item(ph));
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending() > 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("indexed_insert_erase_array_tb: PASS");
    end else begin
      $display("indexed_insert_erase_array_tb: FAIL");
    end
    $finish;
  end

endmodule
